[design/depth_pixel_to_world_point_assert.svh]
`ifndef DEPTH_PIXEL_TO_WORLD_POINT_ASSERT_SVH
`define DEPTH_PIXEL_TO_WORLD_POINT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define DPW_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define DPW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/dpw_pkg.sv]
package dpw_pkg;

  localparam int COLUMN_BITS = 10;
  localparam int ROW_BITS    = 10;
  localparam int PIPE_DEPTH  = 6;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_PRINCIPAL_POINT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_FOCAL   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_UNIT      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROTATION_ROW_X  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ROTATION_ROW_Y  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ROTATION_ROW_Z  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANSLATION_XY  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANSLATION_Z   = 3'd7;

  localparam logic [23:0] PRINCIPAL_POINT_RST = 24'd2667003;
  localparam logic [47:0] INVERSE_FOCAL_RST   = 48'd139107321660938;
  localparam logic [23:0] DEPTH_UNIT_RST      = 24'd429497;
  localparam logic [47:0] ROTATION_ROW_X_RST  = 48'd70368744177664;
  localparam logic [47:0] ROTATION_ROW_Y_RST  = 48'd1073741824;
  localparam logic [47:0] ROTATION_ROW_Z_RST  = 48'd16384;
  localparam logic [63:0] TRANSLATION_XY_RST  = 64'd0;
  localparam logic [31:0] TRANSLATION_Z_RST   = 32'd0;

  // camera-space widths
  localparam int OFS_W  = 14;  // 2u - cx, signed
  localparam int PROJ_W = 38;  // offset times reciprocal focal, signed
  localparam int LO_W   = 19;  // low split of PROJ_W for the z multiply
  localparam int HI_W   = PROJ_W - LO_W;
  localparam int Z_W    = 24;
  localparam int CAM_W  = 30;
  localparam int ROT_W  = 16;
  localparam int PROD_W = ROT_W + CAM_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int RND_W  = ACC_W - 14;

  typedef struct packed {
    logic [COLUMN_BITS-1:0] pixel_column;
    logic [ROW_BITS-1:0]    pixel_row;
    logic [15:0]            depth_raw;
    logic [7:0]             blue_in;
    logic [7:0]             green_in;
    logic [7:0]             red_in;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic [7:0]         blue_out;
    logic [7:0]         green_out;
    logic [7:0]         red_out;
  } point_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  typedef struct packed {
    logic signed [CAM_W-1:0] x;
    logic signed [CAM_W-1:0] y;
    logic [Z_W-1:0]          z;
    color_t                  color;
  } cam_point_t;

  typedef struct packed {
    logic [11:0] cx;
    logic [11:0] cy;
    logic [23:0] ifx;
    logic [23:0] ify;
    logic [23:0] unit;
  } cam_cfg_t;

  typedef struct packed {
    logic [2:0][2:0][ROT_W-1:0] rot;    // [row][2 - column]
    logic [2:0][31:0]           trans;  // [2 - row]
  } pose_cfg_t;

endpackage

[design/dpw_backproject.sv]
module dpw_backproject import dpw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cam_cfg_t   cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  pixel_t     in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output cam_point_t out_data
);

  logic s1_valid, s2_valid, s3_valid;
  logic en1, en2, en3;

  // stage 1: depth to metres, pixel offsets times reciprocal focal
  logic [Z_W-1:0]           s1_z;
  logic signed [PROJ_W-1:0] s1_ax, s1_ay;
  color_t                   s1_color;
  logic [40:0]              z_sum;
  logic signed [OFS_W-1:0]  dx, dy;
  logic signed [PROJ_W-1:0] ax_next, ay_next;

  // stage 2: split products with z
  logic [LO_W+Z_W-1:0]        s2_xlo, s2_ylo;
  logic signed [HI_W+Z_W:0]   s2_xhi, s2_yhi;
  logic [Z_W-1:0]             s2_z;
  color_t                     s2_color;
  logic [LO_W+Z_W-1:0]        xlo_next, ylo_next;
  logic signed [HI_W+Z_W:0]   xhi_next, yhi_next;

  // stage 3: recombine and round
  cam_point_t               s3;
  logic [PROJ_W+Z_W:0]      xsum, ysum;

  assign en3      = !s3_valid || out_ready;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  always_comb begin
    z_sum = 41'(in_data.depth_raw) * 41'(cfg.unit) + 41'd32768;
    dx = $signed({{(OFS_W-COLUMN_BITS-1){1'b0}}, in_data.pixel_column, 1'b0})
       - $signed({{(OFS_W-12){1'b0}}, cfg.cx});
    dy = $signed({{(OFS_W-ROW_BITS-1){1'b0}}, in_data.pixel_row, 1'b0})
       - $signed({{(OFS_W-12){1'b0}}, cfg.cy});
    ax_next = dx * $signed({1'b0, cfg.ifx});
    ay_next = dy * $signed({1'b0, cfg.ify});
  end

  always_comb begin
    xlo_next = (LO_W+Z_W)'(s1_ax[LO_W-1:0]) * (LO_W+Z_W)'(s1_z);
    ylo_next = (LO_W+Z_W)'(s1_ay[LO_W-1:0]) * (LO_W+Z_W)'(s1_z);
    xhi_next = $signed(s1_ax[PROJ_W-1:LO_W]) * $signed({1'b0, s1_z});
    yhi_next = $signed(s1_ay[PROJ_W-1:LO_W]) * $signed({1'b0, s1_z});
  end

  always_comb begin
    xsum = {s2_xhi, {LO_W{1'b0}}} + {{(HI_W+1){1'b0}}, s2_xlo} + (63'd1 << 32);
    ysum = {s2_yhi, {LO_W{1'b0}}} + {{(HI_W+1){1'b0}}, s2_ylo} + (63'd1 << 32);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= in_valid;
      if (en2) s2_valid <= s1_valid;
      if (en3) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_z     <= z_sum[Z_W+15:16];
      s1_ax    <= ax_next;
      s1_ay    <= ay_next;
      s1_color <= '{blue: in_data.blue_in, green: in_data.green_in, red: in_data.red_in};
    end
    if (en2) begin
      s2_xlo   <= xlo_next;
      s2_ylo   <= ylo_next;
      s2_xhi   <= xhi_next;
      s2_yhi   <= yhi_next;
      s2_z     <= s1_z;
      s2_color <= s1_color;
    end
    if (en3) begin
      s3.x     <= $signed(xsum[PROJ_W+Z_W:33]);
      s3.y     <= $signed(ysum[PROJ_W+Z_W:33]);
      s3.z     <= s2_z;
      s3.color <= s2_color;
    end
  end

  assign out_valid = s3_valid;
  assign out_data  = s3;

endmodule

[design/dpw_transform.sv]
module dpw_transform import dpw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  pose_cfg_t  cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  cam_point_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output point_t     out_data
);

  logic s4_valid, s5_valid, s6_valid;
  logic en4, en5, en6;

  logic signed [CAM_W-1:0]  cam [3];
  logic signed [PROD_W-1:0] prod_next [3][3];
  logic signed [PROD_W-1:0] s4_prod [3][3];
  color_t                   s4_color;

  logic signed [ACC_W-1:0]  acc [3];
  logic signed [RND_W-1:0]  s5_rnd [3];
  color_t                   s5_color;

  logic signed [34:0]       wsum [3];
  logic [2:0][31:0]         wsat;
  point_t                   s6;

  assign en6      = !s6_valid || out_ready;
  assign en5      = !s5_valid || en6;
  assign en4      = !s4_valid || en5;
  assign in_ready = en4;

  always_comb begin
    cam[0] = in_data.x;
    cam[1] = in_data.y;
    cam[2] = $signed({{(CAM_W-Z_W){1'b0}}, in_data.z});
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        prod_next[k][j] = $signed(cfg.rot[k][2-j]) * cam[j];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = ACC_W'(s4_prod[k][0]) + ACC_W'(s4_prod[k][1])
             + ACC_W'(s4_prod[k][2]) + ACC_W'(15'sd8192);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wsum[k] = 35'(s5_rnd[k]) + 35'($signed(cfg.trans[2-k]));
      if (wsum[k][34:31] == 4'b0000 || wsum[k][34:31] == 4'b1111) begin
        wsat[k] = wsum[k][31:0];
      end else if (wsum[k][34]) begin
        wsat[k] = 32'h8000_0000;
      end else begin
        wsat[k] = 32'h7fff_ffff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else begin
      if (en4) s4_valid <= in_valid;
      if (en5) s5_valid <= s4_valid;
      if (en6) s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_prod  <= prod_next;
      s4_color <= in_data.color;
    end
    if (en5) begin
      for (int k = 0; k < 3; k++) begin
        s5_rnd[k] <= acc[k][ACC_W-1:14];
      end
      s5_color <= s4_color;
    end
    if (en6) begin
      s6.world_x   <= wsat[0];
      s6.world_y   <= wsat[1];
      s6.world_z   <= wsat[2];
      s6.blue_out  <= s5_color.blue;
      s6.green_out <= s5_color.green;
      s6.red_out   <= s5_color.red;
    end
  end

  assign out_valid = s6_valid;
  assign out_data  = s6;

endmodule

[design/depth_pixel_to_world_point.sv]
// Depth pixel to world point.
// Pixel channel: pixel_valid / pixel_ready / pixel carry one RGB-D sample per
// transaction. A sample with zero depth is taken and dropped, no result.
// Point channel: point_valid / point_ready / point carry the world point in
// saturated Q16.16 with the color passed through, in input order.
// Config: cfg_write with cfg_index and cfg_data writes one register in the
// same cycle; write only while no transaction is in flight.
// Pipeline: six register stages, three of back-projection and three of rotation,
// rounding and translation.
// Throughput: one pixel per cycle unless point_ready stalls; each stage holds one
// transaction and the four 19x24 and nine 16x30 multiplies are each fully pipelined.
// Stall: a low point_ready holds the output stage; the stall walks back one
// stage per occupied slot, so empty slots still fill and pixel_ready drops
// only once every stage ahead of it is full.
// Reset: all stage valids clear and the registers return to their defaults
// (identity pose, 518/519 pixel focal lengths, 0.1 mm depth unit).
`include "depth_pixel_to_world_point_assert.svh"

module depth_pixel_to_world_point import dpw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_ready,
  input  pixel_t                 pixel,
  output logic                   point_valid,
  input  logic                   point_ready,
  output point_t                 point,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [23:0] principal_point;
  logic [47:0] inverse_focal;
  logic [23:0] depth_unit;
  logic [47:0] rotation_row_x;
  logic [47:0] rotation_row_y;
  logic [47:0] rotation_row_z;
  logic [63:0] translation_xy;
  logic [31:0] translation_z;

  cam_cfg_t   cam_cfg;
  pose_cfg_t  pose_cfg;
  logic       bp_in_valid;
  logic       cam_valid, cam_ready;
  cam_point_t cam_point;
  logic       point_tx, pixel_tx;
  logic [2:0] flight;

  always_ff @(posedge clk) begin
    if (rst) begin
      principal_point <= PRINCIPAL_POINT_RST;
      inverse_focal   <= INVERSE_FOCAL_RST;
      depth_unit      <= DEPTH_UNIT_RST;
      rotation_row_x  <= ROTATION_ROW_X_RST;
      rotation_row_y  <= ROTATION_ROW_Y_RST;
      rotation_row_z  <= ROTATION_ROW_Z_RST;
      translation_xy  <= TRANSLATION_XY_RST;
      translation_z   <= TRANSLATION_Z_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PRINCIPAL_POINT: principal_point <= cfg_data[23:0];
        REG_INVERSE_FOCAL:   inverse_focal   <= cfg_data[47:0];
        REG_DEPTH_UNIT:      depth_unit      <= cfg_data[23:0];
        REG_ROTATION_ROW_X:  rotation_row_x  <= cfg_data[47:0];
        REG_ROTATION_ROW_Y:  rotation_row_y  <= cfg_data[47:0];
        REG_ROTATION_ROW_Z:  rotation_row_z  <= cfg_data[47:0];
        REG_TRANSLATION_XY:  translation_xy  <= cfg_data;
        REG_TRANSLATION_Z:   translation_z   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cam_cfg.cx   = principal_point[23:12];
    cam_cfg.cy   = principal_point[11:0];
    cam_cfg.ifx  = inverse_focal[47:24];
    cam_cfg.ify  = inverse_focal[23:0];
    cam_cfg.unit = depth_unit;
    pose_cfg.rot[0] = rotation_row_x;
    pose_cfg.rot[1] = rotation_row_y;
    pose_cfg.rot[2] = rotation_row_z;
    pose_cfg.trans[2] = translation_xy[63:32];
    pose_cfg.trans[1] = translation_xy[31:0];
    pose_cfg.trans[0] = translation_z;
  end

  assign bp_in_valid = pixel_valid && (pixel.depth_raw != 16'd0);

  dpw_backproject u_backproject (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cam_cfg),
    .in_valid  (bp_in_valid),
    .in_ready  (pixel_ready),
    .in_data   (pixel),
    .out_valid (cam_valid),
    .out_ready (cam_ready),
    .out_data  (cam_point)
  );

  dpw_transform u_transform (
    .clk       (clk),
    .rst       (rst),
    .cfg       (pose_cfg),
    .in_valid  (cam_valid),
    .in_ready  (cam_ready),
    .in_data   (cam_point),
    .out_valid (point_valid),
    .out_ready (point_ready),
    .out_data  (point)
  );

  // points in flight, for checking only
  assign pixel_tx = bp_in_valid && pixel_ready;
  assign point_tx = point_valid && point_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      flight <= 3'd0;
    end else begin
      flight <= flight + 3'(pixel_tx) - 3'(point_tx);
    end
  end

  `DPW_ASSERT_IMPLY(a_flight_bound, 1'b1, flight <= 3'(PIPE_DEPTH), "too many points in flight")
  `DPW_ASSERT_IMPLY(a_empty_no_out, flight == 3'd0, !point_valid, "point without a pixel")
  `DPW_ASSERT_IMPLY(a_ready_chain, point_ready, pixel_ready, "pipeline blocked while drained")
  `DPW_ASSERT_NEXT(a_drop_zero, flight == 3'd0 && !pixel_tx, !point_valid, "dropped pixel emitted")

endmodule
